### src/rcd_pkg.sv
// ----------------------------------------------------------------------------
// rcd_pkg
// Shared widths, register indexes and helpers for the rotation-invariant
// colour code distance pipeline.
// ----------------------------------------------------------------------------
package rcd_pkg;

    localparam int MAX_PIXELS = 8;
    localparam int COLOR_W    = 3;
    localparam int CODE_W     = MAX_PIXELS * COLOR_W;
    localparam int COST_W     = 8;
    localparam int TABLE_W    = 64;
    localparam int HUES_W     = 4;
    localparam int SQ_W       = 8;
    localparam int HALF_W     = 10;
    localparam int DIST_W     = 11;
    localparam int IDX_W      = 1;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam logic [IDX_W-1:0] REG_COST_TABLE = 1'b0;
    localparam logic [IDX_W-1:0] REG_HUES       = 1'b1;

    function automatic logic [COST_W-1:0] cost_lookup(
        input logic [TABLE_W-1:0] table_bits,
        input logic [COLOR_W-1:0] diff
    );
        logic [TABLE_W-1:0] shifted;
        shifted = table_bits >> {diff, 3'b000};
        return shifted[COST_W-1:0];
    endfunction

    function automatic logic [COLOR_W-1:0] abs_diff(
        input logic [COLOR_W-1:0] a,
        input logic [COLOR_W-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [DIST_W-1:0] min_dist(
        input logic [DIST_W-1:0] a,
        input logic [DIST_W-1:0] b
    );
        return (b < a) ? b : a;
    endfunction

endpackage

### src/rcd_cost.sv
// ----------------------------------------------------------------------------
// rcd_cost
// Stage 1: per-rotation, per-position cost lookup and the squared hue count.
// ----------------------------------------------------------------------------
module rcd_cost #(
    parameter int NUM_PIXELS = rcd_pkg::MAX_PIXELS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [rcd_pkg::CODE_W-1:0]  i_own,
    input  logic [rcd_pkg::CODE_W-1:0]  i_other,
    input  logic                        i_skip,
    input  logic [rcd_pkg::TABLE_W-1:0] i_cost_table,
    input  logic [rcd_pkg::HUES_W-1:0]  i_hues,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [rcd_pkg::COST_W-1:0]  o_cost [NUM_PIXELS][NUM_PIXELS],
    output logic                        o_skip,
    output logic [rcd_pkg::SQ_W-1:0]    o_hues_sq
);
    import rcd_pkg::*;

    logic              r_valid;
    logic [COST_W-1:0] n_cost [NUM_PIXELS][NUM_PIXELS];
    logic [COST_W-1:0] r_cost [NUM_PIXELS][NUM_PIXELS];
    logic              r_skip;
    logic [SQ_W-1:0]   r_hues_sq;
    logic [SQ_W-1:0]   n_hues_sq;

    // own position i meets other position (r + i) mod N
    for (genvar r = 0; r < NUM_PIXELS; r++) begin : g_rot
        for (genvar i = 0; i < NUM_PIXELS; i++) begin : g_pos
            localparam int J = (r + i) % NUM_PIXELS;
            assign n_cost[r][i] = cost_lookup(i_cost_table,
                abs_diff(i_own[COLOR_W*i +: COLOR_W], i_other[COLOR_W*J +: COLOR_W]));
        end
    end

    assign n_hues_sq = SQ_W'(i_hues) * SQ_W'(i_hues);
    assign o_ready   = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_cost    <= n_cost;
            r_skip    <= i_skip;
            r_hues_sq <= n_hues_sq;
        end
    end

    assign o_valid   = r_valid;
    assign o_cost    = r_cost;
    assign o_skip    = r_skip;
    assign o_hues_sq = r_hues_sq;

endmodule

### src/rcd_sum.sv
// ----------------------------------------------------------------------------
// rcd_sum
// Stages 2 and 3: half sums per rotation, then the full rotation sums.
// The starting bound is formed alongside.
// ----------------------------------------------------------------------------
module rcd_sum #(
    parameter int NUM_PIXELS = rcd_pkg::MAX_PIXELS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [rcd_pkg::COST_W-1:0] i_cost [NUM_PIXELS][NUM_PIXELS],
    input  logic                       i_skip,
    input  logic [rcd_pkg::SQ_W-1:0]   i_hues_sq,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [rcd_pkg::DIST_W-1:0] o_sum [NUM_PIXELS],
    output logic                       o_skip,
    output logic [rcd_pkg::DIST_W-1:0] o_bound
);
    import rcd_pkg::*;

    localparam int HALF = (NUM_PIXELS + 1) / 2;

    logic              r_valid_a;
    logic              ready_a;
    logic [HALF_W-1:0] n_lo [NUM_PIXELS];
    logic [HALF_W-1:0] n_hi [NUM_PIXELS];
    logic [HALF_W-1:0] r_lo [NUM_PIXELS];
    logic [HALF_W-1:0] r_hi [NUM_PIXELS];
    logic              r_skip_a;
    logic [DIST_W-1:0] r_bound_a;

    logic              r_valid_b;
    logic              ready_b;
    logic [DIST_W-1:0] r_sum [NUM_PIXELS];
    logic              r_skip_b;
    logic [DIST_W-1:0] r_bound_b;

    always_comb begin
        for (int r = 0; r < NUM_PIXELS; r++) begin
            n_lo[r] = '0;
            n_hi[r] = '0;
            for (int i = 0; i < NUM_PIXELS; i++) begin
                if (i < HALF) begin
                    n_lo[r] = n_lo[r] + HALF_W'(i_cost[r][i]);
                end else begin
                    n_hi[r] = n_hi[r] + HALF_W'(i_cost[r][i]);
                end
            end
        end
    end

    assign ready_b = !r_valid_b || i_ready;
    assign ready_a = !r_valid_a || ready_b;
    assign o_ready = ready_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else begin
            if (ready_a) begin
                r_valid_a <= i_valid;
            end
            if (ready_b) begin
                r_valid_b <= r_valid_a;
            end
        end
        if (ready_a && i_valid) begin
            r_lo      <= n_lo;
            r_hi      <= n_hi;
            r_skip_a  <= i_skip;
            r_bound_a <= DIST_W'(NUM_PIXELS) * DIST_W'(i_hues_sq);
        end
        if (ready_b && r_valid_a) begin
            for (int r = 0; r < NUM_PIXELS; r++) begin
                r_sum[r] <= DIST_W'(r_lo[r]) + DIST_W'(r_hi[r]);
            end
            r_skip_b  <= r_skip_a;
            r_bound_b <= r_bound_a;
        end
    end

    assign o_valid = r_valid_b;
    assign o_sum   = r_sum;
    assign o_skip  = r_skip_b;
    assign o_bound = r_bound_b;

endmodule

### src/rcd_min.sv
// ----------------------------------------------------------------------------
// rcd_min
// Stages 4 and 5: pairwise minimum over rotations, then the final minimum
// against the starting bound into the output register.
// ----------------------------------------------------------------------------
module rcd_min #(
    parameter int NUM_PIXELS = rcd_pkg::MAX_PIXELS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [rcd_pkg::DIST_W-1:0] i_sum [NUM_PIXELS],
    input  logic                       i_skip,
    input  logic [rcd_pkg::DIST_W-1:0] i_bound,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [rcd_pkg::DIST_W-1:0] o_min
);
    import rcd_pkg::*;

    localparam int PAIRS = MAX_PIXELS / 2;

    logic [DIST_W-1:0] lane [MAX_PIXELS];
    logic              r_valid_c;
    logic              ready_c;
    logic [DIST_W-1:0] r_pair [PAIRS];
    logic [DIST_W-1:0] r_bound_c;

    logic              r_valid_d;
    logic              ready_d;
    logic [DIST_W-1:0] n_min;
    logic [DIST_W-1:0] r_min;

    // absent or skipped rotations read as all ones: never below the bound
    for (genvar r = 0; r < MAX_PIXELS; r++) begin : g_lane
        if (r < NUM_PIXELS) begin : g_used
            if (r == 0) begin : g_first
                assign lane[r] = i_skip ? DIST_MAX : i_sum[r];
            end else begin : g_rest
                assign lane[r] = i_sum[r];
            end
        end else begin : g_pad
            assign lane[r] = DIST_MAX;
        end
    end

    always_comb begin
        n_min = r_bound_c;
        for (int p = 0; p < PAIRS; p++) begin
            n_min = min_dist(n_min, r_pair[p]);
        end
    end

    assign ready_d = !r_valid_d || i_ready;
    assign ready_c = !r_valid_c || ready_d;
    assign o_ready = ready_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_c <= 1'b0;
            r_valid_d <= 1'b0;
        end else begin
            if (ready_c) begin
                r_valid_c <= i_valid;
            end
            if (ready_d) begin
                r_valid_d <= r_valid_c;
            end
        end
        if (ready_c && i_valid) begin
            for (int p = 0; p < PAIRS; p++) begin
                r_pair[p] <= min_dist(lane[2*p], lane[2*p+1]);
            end
            r_bound_c <= i_bound;
        end
        if (ready_d && r_valid_c) begin
            r_min <= n_min;
        end
    end

    assign o_valid = r_valid_d;
    assign o_min   = r_min;

endmodule

### src/rotation_invariant_code_distance.sv
// ----------------------------------------------------------------------------
// rotation_invariant_code_distance
// Smallest summed cost over the cyclic rotations of one ring colour code against
// another, identity skipped on i_skip_identity, bounded by pixels * hues * hues.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------
//  input   | i_valid / o_ready   | i_own_colors, i_other_colors, i_skip_identity
//  output  | o_valid / i_ready   | o_min_distance
//  config  | i_cfg_we            | i_cfg_index, i_cfg_data
//
//  Five register stages: cost lookup, half sums, rotation sums, pair minima,
//  final minimum. One request per cycle while the output is not stalled.
//  Each stage has its own valid bit and takes new data when it is empty or
//  its successor takes its contents, so bubbles close up under a stall.
//  Synchronous active-low reset clears the valid bits, the cost table (0)
//  and the hue count (8).
// ----------------------------------------------------------------------------
module rotation_invariant_code_distance #(
    parameter int NUM_PIXELS = rcd_pkg::MAX_PIXELS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [rcd_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [rcd_pkg::TABLE_W-1:0] i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [rcd_pkg::CODE_W-1:0]  i_own_colors,
    input  logic [rcd_pkg::CODE_W-1:0]  i_other_colors,
    input  logic                        i_skip_identity,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [rcd_pkg::DIST_W-1:0]  o_min_distance
);
    import rcd_pkg::*;

    logic [TABLE_W-1:0] r_cost_table;
    logic [HUES_W-1:0]  r_hues;

    logic               cost_valid;
    logic               cost_ready;
    logic [COST_W-1:0]  cost [NUM_PIXELS][NUM_PIXELS];
    logic               cost_skip;
    logic [SQ_W-1:0]    cost_hues_sq;

    logic               sum_valid;
    logic               sum_ready;
    logic [DIST_W-1:0]  sum [NUM_PIXELS];
    logic               sum_skip;
    logic [DIST_W-1:0]  sum_bound;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cost_table <= '0;
            r_hues       <= HUES_W'(MAX_PIXELS);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_COST_TABLE: r_cost_table <= i_cfg_data;
                REG_HUES:       r_hues       <= i_cfg_data[HUES_W-1:0];
                default:        ;
            endcase
        end
    end

    rcd_cost #(.NUM_PIXELS(NUM_PIXELS)) u_cost (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_own       (i_own_colors),
        .i_other     (i_other_colors),
        .i_skip      (i_skip_identity),
        .i_cost_table(r_cost_table),
        .i_hues      (r_hues),
        .o_valid     (cost_valid),
        .i_ready     (cost_ready),
        .o_cost      (cost),
        .o_skip      (cost_skip),
        .o_hues_sq   (cost_hues_sq)
    );

    rcd_sum #(.NUM_PIXELS(NUM_PIXELS)) u_sum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (cost_valid),
        .o_ready  (cost_ready),
        .i_cost   (cost),
        .i_skip   (cost_skip),
        .i_hues_sq(cost_hues_sq),
        .o_valid  (sum_valid),
        .i_ready  (sum_ready),
        .o_sum    (sum),
        .o_skip   (sum_skip),
        .o_bound  (sum_bound)
    );

    rcd_min #(.NUM_PIXELS(NUM_PIXELS)) u_min (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(sum_valid),
        .o_ready(sum_ready),
        .i_sum  (sum),
        .i_skip (sum_skip),
        .i_bound(sum_bound),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_min  (o_min_distance)
    );

endmodule

### src/rcd_checker.sv
// ----------------------------------------------------------------------------
// rcd_checker
// Port-level checks on the distance pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module rcd_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_ready,
    input logic                       o_valid,
    input logic                       i_ready,
    input logic [rcd_pkg::DIST_W-1:0] o_min_distance
);
    import rcd_pkg::*;

    localparam logic [DIST_W-1:0] MAX_RESULT = DIST_W'(MAX_PIXELS * 255);

    // a request waiting on the output must not change or vanish
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_min_distance))
        else $error("result changed while stalled");

    // back-pressure on the input only comes from a full output
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input stalled with empty output");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_min_distance <= MAX_RESULT)
        else $error("distance out of range");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind rotation_invariant_code_distance rcd_checker u_rcd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_min_distance(o_min_distance)
);

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rotation_invariant_code_distance. A scoreboard
// works out the minimum rotation cost of each accepted request from its own
// copy of the cost table and hue count, and compares it with the results in
// order. Directed cases cover the extremes, then random phases with new
// register settings, random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module testbench;

    import rcd_pkg::*;

    localparam int PIXELS     = MAX_PIXELS;
    localparam int PHASES     = 10;
    localparam int PHASE_REQS = 125;
    localparam int LONG_HOLD  = 60;
    localparam int DRAIN      = 20;
    localparam int LIMIT      = 400000;

    // ------------------------------------------------------------------------
    class distance_scoreboard;
        logic [TABLE_W-1:0] cost_table;
        logic [HUES_W-1:0]  hue_count;
        logic [DIST_W-1:0]  expected_distances[$];
        int                 failures;

        function new();
            cost_table = '0;
            hue_count  = 4'd8;
            failures   = 0;
        endfunction

        function void set_register(input logic [IDX_W-1:0] idx,
                                   input logic [TABLE_W-1:0] data);
            if (idx == REG_COST_TABLE) begin
                cost_table = data;
            end else if (idx == REG_HUES) begin
                hue_count = data[HUES_W-1:0];
            end
        endfunction

        function logic [DIST_W-1:0] predict_min_distance(
            input logic [CODE_W-1:0] own,
            input logic [CODE_W-1:0] other,
            input logic              skip
        );
            int unsigned        best;
            int unsigned        sum;
            int unsigned        pos;
            logic [COLOR_W-1:0] a;
            logic [COLOR_W-1:0] b;
            logic [COLOR_W-1:0] d;
            best = PIXELS * hue_count * hue_count;
            for (int r = (skip ? 1 : 0); r < PIXELS; r++) begin
                sum = 0;
                for (int i = 0; i < PIXELS; i++) begin
                    pos = (r + i) % PIXELS;
                    a   = own[COLOR_W*i +: COLOR_W];
                    b   = other[COLOR_W*pos +: COLOR_W];
                    d   = (a > b) ? a - b : b - a;
                    sum += cost_table[COST_W*d +: COST_W];
                end
                if (sum < best) begin
                    best = sum;
                end
            end
            return best[DIST_W-1:0];
        endfunction

        function void note_request(input logic [CODE_W-1:0] own,
                                   input logic [CODE_W-1:0] other,
                                   input logic skip);
            expected_distances = {expected_distances,
                                  predict_min_distance(own, other, skip)};
        endfunction

        function void check_result(input logic [DIST_W-1:0] got);
            logic [DIST_W-1:0] want;
            if (expected_distances.size() == 0) begin
                if (failures < 10) begin
                    $display("unexpected result: min_distance %0d", got);
                end
                failures++;
            end else begin
                want = expected_distances.pop_front();
                if (got !== want) begin
                    if (failures < 10) begin
                        $display("min_distance mismatch: expected %0d, got %0d",
                                 want, got);
                    end
                    failures++;
                end
            end
        endfunction

        function int pending();
            return expected_distances.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_cfg_we        = 1'b0;
    logic [IDX_W-1:0]     i_cfg_index     = REG_COST_TABLE;
    logic [TABLE_W-1:0]   i_cfg_data      = '0;
    logic                 i_valid         = 1'b0;
    logic                 o_ready;
    logic [CODE_W-1:0]    i_own_colors    = '0;
    logic [CODE_W-1:0]    i_other_colors  = '0;
    logic                 i_skip_identity = 1'b0;
    logic                 o_valid;
    logic                 i_ready         = 1'b1;
    logic [DIST_W-1:0]    o_min_distance;

    distance_scoreboard sb = new();

    int unsigned cycle_count = 0;
    int          gap_pct     = 0;
    int          stall_pct   = 0;
    bit          quiet       = 1'b0;
    bit          hold_output = 1'b0;

    rotation_invariant_code_distance uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_own_colors    (i_own_colors),
        .i_other_colors  (i_other_colors),
        .i_skip_identity (i_skip_identity),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_min_distance  (o_min_distance)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // monitors: handshake values seen here are the pre-edge ones
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            sb.note_request(i_own_colors, i_other_colors, i_skip_identity);
        end
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result(o_min_distance);
        end
    end

    // receiver: short random stalls, plus one long hold so the pipe backs up
    initial begin : rx_side
        bit long_done;
        long_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_output && !long_done) begin
                long_done = 1'b1;
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_ready <= 1'b1;
            end else if (!quiet && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
                i_ready <= 1'b1;
            end
        end
    end

    function automatic logic [CODE_W-1:0] rotate_code(input logic [CODE_W-1:0] code,
                                                      input int shift);
        logic [CODE_W-1:0] out;
        for (int i = 0; i < PIXELS; i++) begin
            out[COLOR_W*((i + shift) % PIXELS) +: COLOR_W] = code[COLOR_W*i +: COLOR_W];
        end
        return out;
    endfunction

    task automatic send_request(input logic [CODE_W-1:0] own,
                                input logic [CODE_W-1:0] other,
                                input logic skip);
        if (!quiet && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_own_colors    <= own;
        i_other_colors  <= other;
        i_skip_identity <= skip;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // registers change only with the pipe empty
    task automatic write_config(input logic [TABLE_W-1:0] costs,
                                input logic [HUES_W-1:0] hues);
        logic [TABLE_W-1:0] hue_word;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        hue_word                = {$urandom(), $urandom()};
        hue_word[HUES_W-1:0]    = hues;
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_COST_TABLE;
        i_cfg_data  <= costs;
        sb.set_register(REG_COST_TABLE, costs);
        @(posedge i_clk);
        i_cfg_index <= REG_HUES;
        i_cfg_data  <= hue_word;
        sb.set_register(REG_HUES, hue_word);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        logic [TABLE_W-1:0] squares;
        logic [TABLE_W-1:0] costs;
        logic [CODE_W-1:0]  ramp;
        logic [CODE_W-1:0]  own;
        logic [CODE_W-1:0]  other;
        logic [HUES_W-1:0]  hues;
        int                 top;
        int                 step;
        int                 pos;

        squares = '0;
        ramp    = '0;
        for (int d = 0; d < PIXELS; d++) begin
            squares[COST_W*d +: COST_W] = COST_W'(d * d);
            ramp[COLOR_W*d +: COLOR_W]  = COLOR_W'(d);
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values: zero table, eight hues
        send_request('0, '0, 1'b0);
        send_request('1, '0, 1'b1);
        send_request(ramp, 24'h123456, 1'b0);

        // top costs, largest bound
        write_config('1, 4'd15);
        send_request('0, '1, 1'b0);
        send_request('1, '1, 1'b1);
        send_request(ramp, ramp, 1'b1);

        // squared differences, rotated and self distances
        write_config(squares, 4'd8);
        send_request(ramp, rotate_code(ramp, 3), 1'b0);
        send_request(ramp, rotate_code(ramp, 3), 1'b1);
        send_request(ramp, ramp, 1'b1);
        send_request(ramp, ramp, 1'b0);
        send_request(24'h249249, 24'h249249, 1'b1);
        send_request('0, '1, 1'b1);

        // zero hues gives a zero bound
        write_config(squares, 4'd0);
        send_request(ramp, '0, 1'b0);

        write_config(squares, 4'd1);
        send_request('1, '0, 1'b1);
        send_request('0, '0, 1'b0);

        // indices at or above the hue count
        write_config({$urandom(), $urandom()}, 4'd3);
        send_request('1, '0, 1'b0);
        send_request('1, 24'h249249, 1'b1);

        write_config(64'h0102_0408_1020_4080, 4'd9);
        send_request(CODE_W'($urandom()), CODE_W'($urandom()), 1'b0);
        send_request(CODE_W'($urandom()), CODE_W'($urandom()), 1'b1);

        for (int ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(0, 4))
                0: costs = {$urandom(), $urandom()};
                1: begin
                    for (int d = 0; d < PIXELS; d++) begin
                        costs[COST_W*d +: COST_W] = COST_W'($urandom_range(0, 31));
                    end
                end
                2: costs = squares;
                3: costs = '1;
                default: begin
                    step = $urandom_range(1, 36);
                    for (int d = 0; d < PIXELS; d++) begin
                        costs[COST_W*d +: COST_W] = COST_W'(d * step);
                    end
                end
            endcase
            if (ph == 0) begin
                hues = 4'd15;
            end else if (ph == 1) begin
                hues = 4'd0;
            end else if ($urandom_range(0, 4) == 0) begin
                hues = HUES_W'($urandom_range(0, 15));
            end else begin
                hues = HUES_W'($urandom_range(1, 8));
            end
            write_config(costs, hues);

            quiet     = (ph == PHASES - 1);
            gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            if (ph == 2) begin
                hold_output = 1'b1;
            end

            for (int n = 0; n < PHASE_REQS; n++) begin
                // in-range indices on a coin toss when the hue count is a sane one
                top = (hues >= 1 && hues <= 8 && $urandom_range(0, 1)) ? hues - 1 : 7;
                for (int i = 0; i < PIXELS; i++) begin
                    own[COLOR_W*i +: COLOR_W] = COLOR_W'($urandom_range(0, top));
                end
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        other = rotate_code(own, $urandom_range(0, PIXELS - 1));
                        repeat ($urandom_range(0, 2)) begin
                            pos = $urandom_range(0, PIXELS - 1);
                            other[COLOR_W*pos +: COLOR_W] = COLOR_W'($urandom_range(0, top));
                        end
                    end
                    4: other = own;
                    5, 6: begin
                        for (int i = 0; i < PIXELS; i++) begin
                            other[COLOR_W*i +: COLOR_W] = COLOR_W'($urandom_range(0, top));
                        end
                    end
                    default: begin
                        own   = CODE_W'($urandom());
                        other = CODE_W'($urandom());
                    end
                endcase
                send_request(own, other, 1'($urandom_range(0, 1)));
            end
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
